// ===== sv/register_write_delay_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Register write delay encoder: assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef REGISTER_WRITE_DELAY_ENCODER_DEFINES_SVH
`define REGISTER_WRITE_DELAY_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while in reset.
`define RWDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored while in reset.
`define RWDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rwde_pkg.sv =====
// ----------------------------------------------------------------------------
// Register write delay encoder package
// Types, record codes and derived widths shared by the encoder modules.
// ----------------------------------------------------------------------------
package rwde_pkg;

  // Configuration of the encoder.
  localparam int TIME_WIDTH      = 32;
  localparam int MAX_GAP_RECORDS = 62;

  // Fixed port widths.
  localparam int TS_W   = 32;
  localparam int BYTE_W = 8;
  localparam int DLY_W  = 16;
  localparam int PEND_W = 9;

  // The timestamp difference saturates at 60 bits before scaling.
  localparam int SAT_W  = 60;
  localparam int DIFF_W = (TIME_WIDTH > SAT_W) ? SAT_W : TIME_WIDTH;
  // The scaled value d*5 keeps at most 62 bits, matching a 64-bit d*20 / 8.
  localparam int S5_W   = (DIFF_W + 3 > 62) ? 62 : DIFF_W + 3;
  localparam int GAP_W  = S5_W - 1;
  localparam int CNT_W  = $clog2(MAX_GAP_RECORDS + 1);

  // Delay constants.
  localparam int FULL_DELAY    = 65535;
  localparam int SHORT_GAP     = 16;
  localparam int PENDING_LIMIT = 300;

  // Command queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Input item codes.
  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_FINISH = 1'b1
  } rwde_mode_t;

  // Result record codes.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DELAY = 2'd1,
    KIND_END   = 2'd2
  } rwde_kind_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic                finish;
    logic [DIFF_W-1:0]   diff;
    logic [BYTE_W-1:0]   addr;
    logic [BYTE_W-1:0]   value;
  } rwde_cmd_t;

endpackage

// ===== sv/rwde_front.sv =====
// ----------------------------------------------------------------------------
// Register write delay encoder: front end
// Accepts requests, tracks the previous timestamp and queues the difference.
// ----------------------------------------------------------------------------
module rwde_front import rwde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [TS_W-1:0]   in_timestamp,
  input  logic [BYTE_W-1:0] in_reg_addr,
  input  logic [BYTE_W-1:0] in_reg_value,
  input  logic              q_full,
  output logic              q_push,
  output rwde_cmd_t         q_cmd
);

  logic [TIME_WIDTH-1:0] prev_time_r, prev_time_nxt;
  logic                  seen_r, seen_nxt;
  logic [TIME_WIDTH-1:0] t_cur;
  logic [TIME_WIDTH-1:0] base;
  logic [TIME_WIDTH-1:0] diff_raw;
  logic [DIFF_W-1:0]     diff_sat;
  logic                  is_finish;

  // Accept whenever the queue has room.
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign is_finish = (in_mode == MODE_FINISH);

  // Timestamp difference against the previous event; backward time is zero.
  always_comb begin
    t_cur    = TIME_WIDTH'(in_timestamp);
    base     = seen_r ? prev_time_r : t_cur;
    diff_raw = (t_cur >= base) ? (t_cur - base) : '0;
    if ((diff_raw >> DIFF_W) != '0) begin
      diff_sat = '1;
    end else begin
      diff_sat = diff_raw[DIFF_W-1:0];
    end
  end

  // Build the queued command.
  always_comb begin
    q_cmd.finish = is_finish;
    q_cmd.diff   = is_finish ? '0 : diff_sat;
    q_cmd.addr   = in_reg_addr;
    q_cmd.value  = in_reg_value;
  end

  // Timestamp history update.
  always_comb begin
    prev_time_nxt = prev_time_r;
    seen_nxt      = seen_r;
    if (q_push) begin
      if (is_finish) begin
        seen_nxt = 1'b0;
      end else begin
        prev_time_nxt = t_cur;
        seen_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      seen_r      <= 1'b0;
    end else begin
      prev_time_r <= prev_time_nxt;
      seen_r      <= seen_nxt;
    end
  end

endmodule

// ===== sv/rwde_queue.sv =====
// ----------------------------------------------------------------------------
// Register write delay encoder: command queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module rwde_queue import rwde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rwde_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output rwde_cmd_t pop_cmd
);

  rwde_cmd_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/rwde_back.sv =====
// ----------------------------------------------------------------------------
// Register write delay encoder: back end
// Scales each queued gap and emits the records one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module rwde_back import rwde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              q_not_empty,
  input  rwde_cmd_t         q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [BYTE_W-1:0] out_addr,
  output logic [BYTE_W-1:0] out_value,
  output logic [DLY_W-1:0]  out_delay,
  output logic              out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAP,
    ST_DELAY,
    ST_END
  } state_t;

  state_t             state_r, state_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]  addr_r, addr_nxt;
  logic [BYTE_W-1:0]  value_r, value_nxt;
  logic [PEND_W-1:0]  pending_r, pending_nxt;
  logic               halve_r, halve_nxt;
  logic               out_valid_r, out_valid_nxt;
  rwde_kind_t         out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0]  out_addr_r, out_addr_nxt;
  logic [BYTE_W-1:0]  out_value_r, out_value_nxt;
  logic [DLY_W-1:0]   out_delay_r, out_delay_nxt;
  logic               out_last_r, out_last_nxt;

  logic [S5_W-1:0]    times5;
  logic [GAP_W-1:0]   gap_scaled;
  logic               out_free;
  logic               gap_big;
  logic               need_delay;

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_addr  = out_addr_r;
  assign out_value = out_value_r;
  assign out_delay = out_delay_r;
  assign out_last  = out_last_r;

  // The output register may load when empty or when its record is taken.
  assign out_free = !out_valid_r || !out_stall;

  // Gap = d*20/8 = d*5/2, or d*5/4 when halving.
  always_comb begin
    times5 = (S5_W'(q_cmd.diff) << 2) + S5_W'(q_cmd.diff);
    if (halve_r) begin
      gap_scaled = {1'b0, times5[S5_W-1:2]};
    end else begin
      gap_scaled = times5[S5_W-1:1];
    end
  end

  assign gap_big    = (gap_r > GAP_W'(FULL_DELAY));
  assign need_delay = !((gap_r < GAP_W'(SHORT_GAP)) &&
                        (pending_r < PEND_W'(PENDING_LIMIT)));

  // Record sequencer.
  always_comb begin
    state_nxt     = state_r;
    gap_nxt       = gap_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    value_nxt     = value_r;
    pending_nxt   = pending_r;
    halve_nxt     = halve_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_value_nxt = out_value_r;
    out_delay_nxt = out_delay_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr_en) begin
      halve_nxt = cfg_wr_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          gap_nxt   = gap_scaled;
          cnt_nxt   = '0;
          addr_nxt  = q_cmd.addr;
          value_nxt = q_cmd.value;
          state_nxt = q_cmd.finish ? ST_END : ST_GAP;
        end
      end
      ST_GAP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (gap_big && (cnt_r != CNT_W'(MAX_GAP_RECORDS))) begin
            // One full-delay record per whole excess, up to MAX_GAP_RECORDS of them.
            out_kind_nxt  = KIND_DELAY;
            out_addr_nxt  = '0;
            out_value_nxt = '0;
            out_delay_nxt = DLY_W'(FULL_DELAY);
            out_last_nxt  = 1'b0;
            gap_nxt       = gap_r - GAP_W'(FULL_DELAY);
            cnt_nxt       = cnt_r + 1'b1;
          end else begin
            // The write record; short gaps join the pending total.
            out_kind_nxt  = KIND_WRITE;
            out_addr_nxt  = addr_r;
            out_value_nxt = value_r;
            out_delay_nxt = '0;
            out_last_nxt  = !need_delay;
            if (need_delay) begin
              state_nxt = ST_DELAY;
            end else begin
              pending_nxt = pending_r + PEND_W'(gap_r[3:0]);
              state_nxt   = ST_IDLE;
            end
          end
        end
      end
      ST_DELAY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DELAY;
          out_addr_nxt  = '0;
          out_value_nxt = '0;
          out_delay_nxt = gap_r[DLY_W-1:0] + DLY_W'(pending_r);
          out_last_nxt  = 1'b1;
          pending_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_END;
          out_addr_nxt  = '0;
          out_value_nxt = '0;
          out_delay_nxt = '0;
          out_last_nxt  = 1'b1;
          pending_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= '0;
      halve_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      halve_r     <= halve_nxt;
      out_valid_r <= out_valid_nxt;
    end
    gap_r       <= gap_nxt;
    cnt_r       <= cnt_nxt;
    addr_r      <= addr_nxt;
    value_r     <= value_nxt;
    out_kind_r  <= out_kind_nxt;
    out_addr_r  <= out_addr_nxt;
    out_value_r <= out_value_nxt;
    out_delay_r <= out_delay_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ===== sv/register_write_delay_encoder.sv =====
// ----------------------------------------------------------------------------
// Register write delay encoder
// Turns timestamped register writes into delay, write and end records.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake             | Payload
//  in_      | request   | in_valid / in_stall   | mode, timestamp, reg_addr, reg_value
//  out_     | record    | out_valid / out_stall | kind, addr, value, delay, last
//  cfg_     | write     | cfg_wr_en             | cfg_wr_data (halve delays)
//
// The back sequencer dequeues and scales a request in its idle state, then
// emits one record per cycle while the output is not stalled: full-delay
// records and the write record with any delay record, or the end record of a
// finish. It sets this rate; the front keeps accepting into a two-entry queue.
// Reset is synchronous and active low; no memory clearing pass is needed.
// A stalled output holds its record; the queue fills and then stalls the input.
// ----------------------------------------------------------------------------
module register_write_delay_encoder import rwde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [TS_W-1:0]   in_timestamp,
  input  logic [BYTE_W-1:0] in_reg_addr,
  input  logic [BYTE_W-1:0] in_reg_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [BYTE_W-1:0] out_addr,
  output logic [BYTE_W-1:0] out_value,
  output logic [DLY_W-1:0]  out_delay,
  output logic              out_last
);

  logic      q_full;
  logic      q_push;
  rwde_cmd_t q_push_cmd;
  logic      q_pop;
  logic      q_not_empty;
  rwde_cmd_t q_pop_cmd;

  // Front end: accept and classify.
  rwde_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_timestamp (in_timestamp),
    .in_reg_addr  (in_reg_addr),
    .in_reg_value (in_reg_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_push_cmd)
  );

  // Decoupling queue.
  rwde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_pop_cmd)
  );

  // Back end: record sequencer.
  rwde_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_not_empty (q_not_empty),
    .q_cmd       (q_pop_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_addr    (out_addr),
    .out_value   (out_value),
    .out_delay   (out_delay),
    .out_last    (out_last)
  );

endmodule

// ===== sv/rwde_checker.sv =====
// ----------------------------------------------------------------------------
// Register write delay encoder: port checker
// Watches the record channel of the top level and flags malformed records.
// ----------------------------------------------------------------------------
`include "register_write_delay_encoder_defines.svh"

module rwde_checker import rwde_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_kind,
  input logic [BYTE_W-1:0] out_addr,
  input logic [BYTE_W-1:0] out_value,
  input logic [DLY_W-1:0]  out_delay,
  input logic              out_last
);

  // A stalled record stays offered with its kind, delay and last flag unchanged.
  `RWDE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_delay) && $stable(out_last), "stalled record changed")

  // An end marker is always the final record of its request.
  `RWDE_ASSERT_NOW(a_end_last, out_valid && (out_kind == KIND_END), out_last && (out_delay == '0), "end marker malformed")

  // Delay records carry no register write.
  `RWDE_ASSERT_NOW(a_delay_clean, out_valid && (out_kind == KIND_DELAY), (out_addr == '0) && (out_value == '0), "delay record carries write data")

  // A write record carries no delay.
  `RWDE_ASSERT_NOW(a_write_clean, out_valid && (out_kind == KIND_WRITE), out_delay == '0, "write record carries a delay")

endmodule

bind register_write_delay_encoder rwde_checker u_rwde_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Register write delay encoder testbench
// Drives timestamped register writes and finish requests into the encoder
// and checks every record against a cycle-free model of the encoding. A short
// table of directed requests comes first, then random streams under both
// settings of delay halving, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
  import rwde_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic {
    ROW_CONFIG,
    ROW_REQUEST
  } row_act_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_LIGHT,
    FLOW_HEAVY,
    FLOW_EVERY_THIRD
  } flow_mode_t;

  typedef struct packed {
    rwde_mode_t        mode;
    logic [TS_W-1:0]   stamp;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] value;
  } request_t;

  typedef struct packed {
    rwde_kind_t        kind;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic [DLY_W-1:0]  delay;
    logic              last;
  } record_t;

  typedef struct {
    row_act_t act;
    logic     halve;
    request_t req;
    bit       typed;
  } plan_row_t;

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              cfg_wr_en    = 1'b0;
  logic              cfg_wr_data  = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic              in_mode      = 1'b0;
  logic [TS_W-1:0]   in_timestamp = '0;
  logic [BYTE_W-1:0] in_reg_addr  = '0;
  logic [BYTE_W-1:0] in_reg_value = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [1:0]        out_kind;
  logic [BYTE_W-1:0] out_addr;
  logic [BYTE_W-1:0] out_value;
  logic [DLY_W-1:0]  out_delay;
  logic              out_last;

  // Model state: previous event time, whether a stream is open, the gathered
  // short gaps and the halving setting.
  logic [TS_W-1:0]   track_stamp   = '0;
  bit                track_seen    = 1'b0;
  logic [PEND_W-1:0] track_pending = '0;
  bit                halve_now     = 1'b0;

  record_t   play_list[$];
  record_t   expected_records[$];
  plan_row_t plan[$];

  int          mismatches  = 0;
  int          cycles      = 0;
  int          burst_left  = 0;
  int          hold_reqs   = 0;
  int          hold_taken  = 0;
  int          hold_left   = 0;
  int          flow_left   = 0;
  flow_mode_t  flow_mode   = FLOW_FREE;
  logic [TS_W-1:0] cursor  = '0;

  register_write_delay_encoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_timestamp (in_timestamp),
    .in_reg_addr  (in_reg_addr),
    .in_reg_value (in_reg_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_addr     (out_addr),
    .out_value    (out_value),
    .out_delay    (out_delay),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records outstanding", cycles,
               expected_records.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic record_t make_record(rwde_kind_t kind, logic [BYTE_W-1:0] addr,
                                          logic [BYTE_W-1:0] value,
                                          logic [DLY_W-1:0] delay);
    record_t rec;
    rec.kind  = kind;
    rec.addr  = addr;
    rec.value = value;
    rec.delay = delay;
    rec.last  = 1'b0;
    return rec;
  endfunction

  // Works out the records of one request into play_list and advances the state.
  function automatic void encode_request(request_t req);
    logic [63:0] span;
    logic [63:0] gap;
    logic [63:0] sum;
    int unsigned fulls;
    record_t     rec;
    play_list.delete();
    if (req.mode == MODE_FINISH) begin
      // The end marker drops any gathered short gaps and closes the stream.
      play_list.push_back(make_record(KIND_END, '0, '0, '0));
      track_seen    = 1'b0;
      track_pending = '0;
    end else begin
      if (!track_seen) begin
        track_stamp = req.stamp;
        track_seen  = 1'b1;
      end
      // A backward timestamp counts as no time passing.
      span = (req.stamp >= track_stamp) ? 64'(req.stamp - track_stamp) : 64'd0;
      gap  = (span * 20) / 8;
      if (halve_now)
        gap = gap >> 1;
      fulls = 0;
      while (gap > FULL_DELAY && fulls < MAX_GAP_RECORDS) begin
        play_list.push_back(make_record(KIND_DELAY, '0, '0, DLY_W'(FULL_DELAY)));
        gap   = gap - FULL_DELAY;
        fulls = fulls + 1;
      end
      track_stamp = req.stamp;
      play_list.push_back(make_record(KIND_WRITE, req.addr, req.value, '0));
      if (gap < SHORT_GAP && track_pending < PENDING_LIMIT) begin
        track_pending = track_pending + gap[PEND_W-1:0];
      end else begin
        // The remainder past the cap wraps to 16 bits with the gathered total.
        sum = gap + 64'(track_pending);
        play_list.push_back(make_record(KIND_DELAY, '0, '0, sum[DLY_W-1:0]));
        track_pending = '0;
      end
    end
    rec      = play_list.pop_back();
    rec.last = 1'b1;
    play_list.push_back(rec);
  endfunction

  function automatic void plan_config(logic halve);
    plan_row_t row;
    row.act   = ROW_CONFIG;
    row.halve = halve;
    row.req   = '0;
    row.typed = 1'b0;
    plan.push_back(row);
  endfunction

  function automatic void plan_request(rwde_mode_t mode, logic [TS_W-1:0] stamp,
                                       logic [BYTE_W-1:0] addr,
                                       logic [BYTE_W-1:0] value, bit typed);
    plan_row_t row;
    row.act        = ROW_REQUEST;
    row.halve      = 1'b0;
    row.req.mode   = mode;
    row.req.stamp  = stamp;
    row.req.addr   = addr;
    row.req.value  = value;
    row.typed      = typed;
    plan.push_back(row);
  endfunction

  function automatic void note_mismatch(string what, record_t want, record_t seen);
    mismatches = mismatches + 1;
    if (mismatches <= REPORT_LIMIT)
      $display("Mismatch at %0t: %s\n  expected kind %0d addr %h value %h delay %0d last %0d\n  actual   kind %0d addr %h value %h delay %0d last %0d",
               $realtime, what, want.kind, want.addr, want.value, want.delay, want.last,
               seen.kind, seen.addr, seen.value, seen.delay, seen.last);
  endfunction

  // Offers one request and holds it until accepted; then records what it owes.
  task automatic send_request(request_t req, bit typed);
    in_valid     <= 1'b1;
    in_mode      <= req.mode;
    in_timestamp <= req.stamp;
    in_reg_addr  <= req.addr;
    in_reg_value <= req.value;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    encode_request(req);
    if (typed) begin
      // A lone write record or end marker, read straight off the request.
      if (req.mode == MODE_FINISH)
        expected_records.push_back('{KIND_END, '0, '0, '0, 1'b1});
      else
        expected_records.push_back('{KIND_WRITE, req.addr, req.value, '0, 1'b1});
    end else begin
      foreach (play_list[i])
        expected_records.push_back(play_list[i]);
    end
  endtask

  // Bursts of back-to-back requests with random gaps between them.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 9);
    end
  endtask

  // Waits for every outstanding record, then writes the halving setting.
  task automatic write_config(logic halve);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= halve;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    halve_now   = halve;
  endtask

  // Next write event: mostly an ordered stream, some jumps back and wild times.
  function automatic request_t next_event(bit creep);
    request_t req;
    int unsigned pick;
    req.mode  = MODE_WRITE;
    req.addr  = BYTE_W'($urandom);
    req.value = BYTE_W'($urandom);
    pick      = $urandom_range(0, 99);
    if (creep)
      req.stamp = cursor + $urandom_range(4, 6);
    else if (pick < 45)
      req.stamp = cursor + $urandom_range(0, 6);
    else if (pick < 70)
      req.stamp = cursor + $urandom_range(7, 26000);
    else if (pick < 85)
      req.stamp = cursor + $urandom_range(26001, 400000);
    else if (pick < 88)
      req.stamp = cursor + $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
    else if (pick < 94 && cursor != 0)
      req.stamp = cursor - $urandom_range(1, cursor);
    else
      req.stamp = $urandom;
    cursor = req.stamp;
    return req;
  endfunction

  // Random streams of writes, most of them closed by a finish request.
  task automatic run_random(int count, bit creep_first, bit hold_first);
    int       sent;
    int       run_len;
    bit       creep;
    request_t req;
    sent = 0;
    if (hold_first) begin
      // The receiver holds off while requests keep coming, filling the block.
      hold_reqs  <= hold_reqs + 1;
      burst_left = 40;
    end
    while (sent < count) begin
      creep   = creep_first && (sent == 0);
      run_len = creep ? $urandom_range(26, 32) : $urandom_range(1, 10);
      for (int i = 0; i < run_len && sent < count; i++) begin
        send_request(next_event(creep), 1'b0);
        sent = sent + 1;
        pace();
      end
      if (sent < count && $urandom_range(0, 9) < 6) begin
        req.mode  = MODE_FINISH;
        req.stamp = $urandom;
        req.addr  = BYTE_W'($urandom);
        req.value = BYTE_W'($urandom);
        send_request(req, 1'b0);
        sent = sent + 1;
        pace();
      end
    end
  endtask

  // Receiver: a long hold-off when asked, otherwise changing stall patterns.
  always @(posedge clk) begin
    if (hold_left == 0 && hold_taken != hold_reqs) begin
      hold_taken = hold_taken + 1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_mode_t'($urandom_range(0, 3));
        flow_left = $urandom_range(16, 96);
      end
      flow_left = flow_left - 1;
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        FLOW_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:    out_stall <= (flow_left % 3 == 0);
      endcase
    end
  end

  // Record checker: each accepted record against the oldest expectation.
  always @(posedge clk) begin
    record_t seen;
    record_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen.kind  = rwde_kind_t'(out_kind);
      seen.addr  = out_addr;
      seen.value = out_value;
      seen.delay = out_delay;
      seen.last  = out_last;
      if (expected_records.size() == 0) begin
        note_mismatch("record with no request waiting", '0, seen);
      end else begin
        want = expected_records.pop_front();
        if (seen !== want)
          note_mismatch("record differs", want, seen);
      end
    end
  end

  initial begin
    // Directed table: first event, repeats, backward time, short gap gathering,
    // the 65535 boundary, the cap on full-delay records, finish, and halving.
    plan_config(1'b0);
    plan_request(MODE_WRITE,  32'hFFFF_FFF0, 8'hFF, 8'h00, 1'b1);
    plan_request(MODE_WRITE,  32'hFFFF_FFF0, 8'h00, 8'hFF, 1'b1);
    plan_request(MODE_WRITE,  32'h0000_0000, 8'h5A, 8'hA5, 1'b1);
    plan_request(MODE_WRITE,  32'd6,         8'h01, 8'h02, 1'b1);
    plan_request(MODE_WRITE,  32'd13,        8'h80, 8'h7F, 1'b0);
    plan_request(MODE_WRITE,  32'd26227,     8'h11, 8'h22, 1'b0);
    plan_request(MODE_WRITE,  32'd52442,     8'h33, 8'h44, 1'b0);
    plan_request(MODE_WRITE,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0);
    plan_request(MODE_FINISH, 32'h0000_0000, 8'h00, 8'h00, 1'b1);
    plan_request(MODE_FINISH, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
    plan_request(MODE_WRITE,  32'h8000_0000, 8'hC3, 8'h3C, 1'b1);
    plan_config(1'b1);
    plan_request(MODE_WRITE,  32'h8000_0007, 8'h0F, 8'hF0, 1'b0);
    plan_request(MODE_WRITE,  32'h8000_0014, 8'hAA, 8'h55, 1'b0);
    plan_request(MODE_WRITE,  32'hFFFF_FFFF, 8'h55, 8'hAA, 1'b0);
    plan_request(MODE_WRITE,  32'h0000_0000, 8'h01, 8'h01, 1'b1);
    plan_request(MODE_FINISH, 32'h1234_5678, 8'h9C, 8'h63, 1'b1);
    plan_config(1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].act == ROW_CONFIG) begin
        write_config(plan[i].halve);
      end else begin
        send_request(plan[i].req, plan[i].typed);
        pace();
      end
    end

    // Random phases; each setting change waits for every record to come out.
    cursor = $urandom;
    write_config(1'b1);
    run_random(40, 1'b1, 1'b0);
    write_config(1'b0);
    run_random(40, 1'b0, 1'b1);
    write_config(1'b1);
    run_random(40, 1'b0, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rwde_pkg.sv
sv/rwde_front.sv
sv/rwde_queue.sv
sv/rwde_back.sv
sv/register_write_delay_encoder.sv
sv/rwde_checker.sv
sim/tb_top.sv
